>>> rtl/core/caps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package caps_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam logic [63:0] KEY_HIGH_RST = 64'h3243544455343071;
    localparam logic [63:0] KEY_LOW_RST  = 64'h4E794367546A6231;
    localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
    localparam logic [15:0] GAP_RST      = 16'd180;
    localparam logic [15:0] POLL_RST     = 16'd500;
    localparam logic [15:0] HOLDOFF_RST  = 16'd220;

    // register indexes
    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_GAP      = 3'd3;
    localparam logic [2:0] REG_POLL     = 3'd4;
    localparam logic [2:0] REG_HOLDOFF  = 3'd5;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PRESS = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_WAIT_CH  = 3'd1,
        PH_WAIT_ACK = 3'd2,
        PH_SETUP    = 3'd3,
        PH_POLL     = 3'd4,
        PH_FAILED   = 3'd5
    } phase_t;

    // frame job codes passed from front to back
    typedef enum logic [2:0] {
        JOB_CHALLENGE = 3'd0,
        JOB_SETUP0    = 3'd1,
        JOB_SETUP1    = 3'd2,
        JOB_SETUP2    = 3'd3,
        JOB_POLL      = 3'd4,
        JOB_AUTH      = 3'd5
    } job_t;

    typedef struct packed {
        job_t        job;
        logic [2:0]  phase;
        logic [31:0] chal;
        logic [63:0] key_high;
        logic [63:0] key_low;
    } job_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_AES  = 2'd1,
        BK_SEND = 2'd2
    } back_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // Fixed frame bytes; the two poll frames form one 26-byte job.
    function automatic logic [7:0] fixed_byte(input job_t job, input logic [4:0] idx);
        logic [7:0] ch [10];
        logic [7:0] s0 [10];
        logic [7:0] s1 [10];
        logic [7:0] s2 [10];
        logic [7:0] pl [26];
        logic [7:0] r;
        ch = '{8'h55,8'hAA,8'h01,8'h11,8'h10,8'h01,8'h00,8'h04,8'hD8,8'hFF};
        s0 = '{8'h55,8'hAA,8'h01,8'h11,8'hA5,8'h01,8'h88,8'h18,8'hA7,8'hFE};
        s1 = '{8'h55,8'hAA,8'h01,8'h11,8'hA5,8'h01,8'h18,8'h18,8'h17,8'hFF};
        s2 = '{8'h55,8'hAA,8'h01,8'h11,8'hF1,8'h01,8'h01,8'h1A,8'hE0,8'hFE};
        pl = '{8'h55,8'hAA,8'h04,8'h11,8'h10,8'h02,8'h42,8'h20,8'h1C,8'h00,8'h00,8'h5A,8'hFF,
               8'h55,8'hAA,8'h04,8'h11,8'h10,8'h02,8'h46,8'hFB,8'h58,8'hFB,8'h69,8'hDB,8'hFC};
        r = 8'h00;
        unique case (job)
            JOB_CHALLENGE: r = (idx < 5'd10) ? ch[idx[3:0]] : 8'h00;
            JOB_SETUP0:    r = (idx < 5'd10) ? s0[idx[3:0]] : 8'h00;
            JOB_SETUP1:    r = (idx < 5'd10) ? s1[idx[3:0]] : 8'h00;
            JOB_SETUP2:    r = (idx < 5'd10) ? s2[idx[3:0]] : 8'h00;
            JOB_POLL:      r = (idx < 5'd26) ? pl[idx] : 8'h00;
            default:       r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/caps_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface caps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        link_up;
    logic [7:0]  rx_length;
    logic [55:0] rx_head;
    logic [31:0] rx_tail;
    modport source (output valid, command, link_up, rx_length, rx_head, rx_tail, input ready);
    modport sink (input valid, command, link_up, rx_length, rx_head, rx_tail, output ready);
endinterface

interface caps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       run_end;
    logic [2:0] phase;
    modport source (output valid, tx_byte, frame_end, run_end, phase, input ready);
    modport sink (input valid, tx_byte, frame_end, run_end, phase, output ready);
endinterface

interface caps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/challenge_auth_poll_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Challenge-response handshake sequencer.
// Channels: in_ch carries one event per transaction (tick, press, received
// frame summary); out_ch carries one transmitted byte per transaction with
// frame_end, run_end and the phase after the event; cfg writes registers
// 0..5 (key high, key low, reply timeout, setup gap, poll interval, holdoff).
// The front decodes an event in the cycle it is accepted and pushes at most
// one frame job into a four-entry queue; it accepts a new event every
// cycle while two queue slots are free.
// The back pops one job, runs ten AES rounds (one per cycle) for an auth
// frame, then, while the receiver is ready, sends one byte per cycle
// through a registered output stage. A poll pair is one 26-byte job.
// Reset clears the phase, timers, queue and output stage; registers return
// to their defaults. A stalled receiver holds the output register; the queue
// then fills and input ready drops.
module challenge_auth_poll_sequencer_top #(
    parameter int TIME_BITS = caps_pkg::TIME_BITS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    caps_in_if.sink     in_ch,
    caps_out_if.source  out_ch,
    caps_cfg_if.sink    cfg
);
    caps_pkg::job_entry_t push_a, push_b;
    logic push_a_en, push_b_en, q_space2;

    caps_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg), .q_space2(q_space2),
        .push_a(push_a), .push_b(push_b), .push_a_en(push_a_en), .push_b_en(push_b_en)
    );

    caps_back u_back (
        .clk(clk), .rst_n(rst_n), .push_a(push_a), .push_b(push_b),
        .push_a_en(push_a_en), .push_b_en(push_b_en), .q_space2(q_space2),
        .out_ch(out_ch)
    );

`ifndef SYNTHESIS
    a_ready_vs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("output valid dropped");
    a_run_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.run_end |-> out_ch.frame_end)
        else $error("run end off frame end");
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.ready)
        else $error("config not ready");
`endif
endmodule
`default_nettype wire

>>> rtl/core/caps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Event decode and handshake state; pushes at most one frame job per event.
module caps_front #(
    parameter int TIME_BITS = caps_pkg::TIME_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    caps_in_if.sink    in_ch,
    caps_cfg_if.sink   cfg,
    input  wire logic  q_space2,
    output caps_pkg::job_entry_t push_a,
    output caps_pkg::job_entry_t push_b,
    output logic       push_a_en,
    output logic       push_b_en
);
    logic [63:0] key_high_reg, key_low_reg;
    logic [15:0] timeout_reg, gap_reg, poll_reg, holdoff_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  step_reg, step_next;
    logic [TIME_BITS-1:0] now_reg, now_next, smark_reg, smark_next;
    logic [TIME_BITS-1:0] pmark_reg, pmark_next, kmark_reg, kmark_next;

    logic [7:0] b [11];
    logic acc;
    logic [TIME_BITS-1:0] now_inc;

    assign in_ch.ready = q_space2;
    assign cfg.ready   = 1'b1;
    assign acc         = in_ch.valid && q_space2;
    assign now_inc     = now_reg + TIME_BITS'(1);

    function automatic logic passed(input logic [TIME_BITS-1:0] nw,
                                    input logic [TIME_BITS-1:0] mk,
                                    input logic [15:0] lim);
        logic [TIME_BITS-1:0] d;
        d = nw - mk;
        return d > TIME_BITS'(lim);
    endfunction

    always_comb
    begin
        for (int i = 0; i < 7; i++)
            b[i] = in_ch.rx_head[8*(6-i) +: 8];
        for (int i = 0; i < 4; i++)
            b[7+i] = in_ch.rx_tail[8*(3-i) +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= caps_pkg::KEY_HIGH_RST;
            key_low_reg  <= caps_pkg::KEY_LOW_RST;
            timeout_reg  <= caps_pkg::TIMEOUT_RST;
            gap_reg      <= caps_pkg::GAP_RST;
            poll_reg     <= caps_pkg::POLL_RST;
            holdoff_reg  <= caps_pkg::HOLDOFF_RST;
        end
        else if (cfg.valid)
        begin
            priority case (cfg.index)
                caps_pkg::REG_KEY_HIGH: key_high_reg <= cfg.data;
                caps_pkg::REG_KEY_LOW:  key_low_reg  <= cfg.data;
                caps_pkg::REG_TIMEOUT:  timeout_reg  <= cfg.data[15:0];
                caps_pkg::REG_GAP:      gap_reg      <= cfg.data[15:0];
                caps_pkg::REG_POLL:     poll_reg     <= cfg.data[15:0];
                caps_pkg::REG_HOLDOFF:  holdoff_reg  <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        now_next   = now_reg;
        smark_next = smark_reg;
        pmark_next = pmark_reg;
        kmark_next = kmark_reg;
        push_a_en  = 1'b0;
        push_b_en  = 1'b0;
        push_a     = '{job: caps_pkg::JOB_CHALLENGE, phase: 3'd0, chal: in_ch.rx_tail,
                       key_high: key_high_reg, key_low: key_low_reg};
        push_b     = push_a;
        push_b.job = caps_pkg::JOB_POLL;
        if (acc)
        begin
            unique case (in_ch.command)
                caps_pkg::CMD_TICK:
                begin
                    now_next = now_inc;
                    if ((phase_reg == caps_pkg::PH_WAIT_CH || phase_reg == caps_pkg::PH_WAIT_ACK)
                        && passed(now_inc, smark_reg, timeout_reg))
                        phase_next = caps_pkg::PH_FAILED;
                    else if (phase_reg == caps_pkg::PH_SETUP
                             && passed(now_inc, smark_reg, gap_reg))
                    begin
                        if (step_reg != 2'd3)
                        begin
                            push_a_en  = in_ch.link_up;
                            push_a.job = caps_pkg::job_t'({1'b0, step_reg} + 3'd1);
                        end
                        else
                        begin
                            phase_next = caps_pkg::PH_POLL;
                            pmark_next = '0;
                        end
                        step_next  = step_reg + 2'd1;
                        smark_next = now_inc;
                    end
                    if (phase_next == caps_pkg::PH_POLL && in_ch.link_up
                        && passed(now_inc, pmark_next, poll_reg))
                    begin
                        pmark_next = now_inc;
                        push_b_en  = 1'b1;
                    end
                end
                caps_pkg::CMD_PRESS:
                begin
                    if (passed(now_reg, kmark_reg, holdoff_reg))
                    begin
                        kmark_next = now_reg;
                        if (phase_reg == caps_pkg::PH_POLL)
                            phase_next = caps_pkg::PH_IDLE;
                        else if (phase_reg == caps_pkg::PH_IDLE
                                 || phase_reg == caps_pkg::PH_FAILED)
                        begin
                            if (!in_ch.link_up)
                                phase_next = caps_pkg::PH_FAILED;
                            else
                            begin
                                push_a_en  = 1'b1;
                                phase_next = caps_pkg::PH_WAIT_CH;
                                smark_next = now_reg;
                                step_next  = 2'd0;
                            end
                        end
                        else
                            phase_next = caps_pkg::PH_FAILED;
                    end
                end
                caps_pkg::CMD_FRAME:
                begin
                    if (phase_reg == caps_pkg::PH_WAIT_CH && in_ch.rx_length >= 8'd13
                        && b[0] == 8'h55 && b[1] == 8'hAA && b[2] == 8'h04 && b[3] == 8'h10
                        && b[4] == 8'h11 && b[5] == 8'h04 && b[6] == 8'h00)
                    begin
                        if (in_ch.link_up)
                        begin
                            push_a_en  = 1'b1;
                            push_a.job = caps_pkg::JOB_AUTH;
                            phase_next = caps_pkg::PH_WAIT_ACK;
                            smark_next = now_reg;
                        end
                        else
                            phase_next = caps_pkg::PH_FAILED;
                    end
                    else if (phase_reg == caps_pkg::PH_WAIT_ACK && in_ch.rx_length >= 8'd10
                             && b[0] == 8'h55 && b[1] == 8'hAA && b[3] == 8'h10
                             && b[4] == 8'h11 && b[5] == 8'h20 && b[7] == 8'h00)
                    begin
                        phase_next = caps_pkg::PH_SETUP;
                        smark_next = now_reg;
                        step_next  = 2'd0;
                    end
                end
                default: ;
            endcase
        end
        push_a.phase = phase_next;
        push_b.phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= caps_pkg::PH_IDLE;
            step_reg  <= 2'd0;
            now_reg   <= '0;
            smark_reg <= '0;
            pmark_reg <= '0;
            kmark_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            now_reg   <= now_next;
            smark_reg <= smark_next;
            pmark_reg <= pmark_next;
            kmark_reg <= kmark_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= caps_pkg::PH_FAILED)
        else $error("phase out of range");
    a_no_push_without_space: assert property (@(posedge clk) disable iff (!rst_n)
        (push_a_en || push_b_en) |-> q_space2)
        else $error("push without queue space");
    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_ch.command == caps_pkg::CMD_TICK) |=> now_reg == $past(now_inc))
        else $error("time did not advance");
`endif
endmodule
`default_nettype wire

>>> rtl/core/caps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Job queue plus byte sender; AES-128 runs one round per cycle for auth jobs.
module caps_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire caps_pkg::job_entry_t push_a,
    input  wire caps_pkg::job_entry_t push_b,
    input  wire logic push_a_en,
    input  wire logic push_b_en,
    output logic      q_space2,
    caps_out_if.source out_ch
);
    localparam int QD = 4;

    caps_pkg::job_entry_t q_mem [QD];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;

    caps_pkg::back_state_t st_reg, st_next;
    caps_pkg::job_entry_t cur_reg;
    logic [4:0] idx_reg, len_reg;
    logic [3:0] rnd_reg;
    logic [7:0] s_reg [16];
    logic [7:0] k_reg [16];
    logic [7:0] rc_reg;
    logic [15:0] sum_reg;

    logic pop, send_fire;
    logic [7:0] byte_c;
    logic [7:0] t [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    logic [7:0] kn [16];
    logic [7:0] hdr [7];

    // Output register stage
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       ofe_reg, ore_reg;
    logic [2:0] oph_reg;
    logic       o_free;

    assign q_space2 = (cnt_reg <= 3'(QD - 2));
    assign o_free   = !ov_reg || out_ch.ready;
    assign pop      = (st_reg == caps_pkg::BK_IDLE) && cnt_reg != 3'd0;
    assign send_fire = (st_reg == caps_pkg::BK_SEND) && o_free;

    always_comb
    begin
        cnt_next = cnt_reg + 3'(push_a_en) + 3'(push_b_en) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a_en)
            q_mem[wp_reg] <= push_a;
        if (push_b_en)
            q_mem[wp_reg + 2'(push_a_en)] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + 2'(push_a_en) + 2'(push_b_en);
            rp_reg  <= rp_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

    // AES round datapath
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            t[i] = caps_pkg::sbox(s_reg[i]);
        for (int i = 0; i < 16; i++)
            sr[i] = t[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)];
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] al;
            al = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c]   = sr[4*c]   ^ al ^ caps_pkg::xt(sr[4*c]   ^ sr[4*c+1]);
            mc[4*c+1] = sr[4*c+1] ^ al ^ caps_pkg::xt(sr[4*c+1] ^ sr[4*c+2]);
            mc[4*c+2] = sr[4*c+2] ^ al ^ caps_pkg::xt(sr[4*c+2] ^ sr[4*c+3]);
            mc[4*c+3] = sr[4*c+3] ^ al ^ caps_pkg::xt(sr[4*c+3] ^ sr[4*c]);
        end
        kn[0] = k_reg[0] ^ caps_pkg::sbox(k_reg[13]) ^ rc_reg;
        kn[1] = k_reg[1] ^ caps_pkg::sbox(k_reg[14]);
        kn[2] = k_reg[2] ^ caps_pkg::sbox(k_reg[15]);
        kn[3] = k_reg[3] ^ caps_pkg::sbox(k_reg[12]);
        for (int i = 4; i < 16; i++)
            kn[i] = k_reg[i] ^ kn[i-4];
    end

    assign hdr = '{8'h55, 8'hAA, 8'h10, 8'h11, 8'h10, 8'h20, 8'h00};

    always_comb
    begin
        byte_c = 8'h00;
        if (cur_reg.job == caps_pkg::JOB_AUTH)
        begin
            if (idx_reg < 5'd7)
                byte_c = hdr[idx_reg[2:0]];
            else if (idx_reg < 5'd23)
                byte_c = s_reg[4'(idx_reg - 5'd7)];
            else if (idx_reg == 5'd23)
                byte_c = ~sum_reg[7:0];
            else
                byte_c = ~sum_reg[15:8];
        end
        else
            byte_c = caps_pkg::fixed_byte(cur_reg.job, idx_reg);
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            caps_pkg::BK_IDLE:
                if (pop)
                    st_next = (q_mem[rp_reg].job == caps_pkg::JOB_AUTH)
                              ? caps_pkg::BK_AES : caps_pkg::BK_SEND;
            caps_pkg::BK_AES:
                if (rnd_reg == 4'd10)
                    st_next = caps_pkg::BK_SEND;
            caps_pkg::BK_SEND:
                if (send_fire && idx_reg == len_reg - 5'd1)
                    st_next = caps_pkg::BK_IDLE;
            default:
                st_next = caps_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= caps_pkg::BK_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_mem[rp_reg];
            idx_reg <= '0;
            rnd_reg <= 4'd1;
            rc_reg  <= 8'h01;
            sum_reg <= 16'd0;
            unique case (q_mem[rp_reg].job)
                caps_pkg::JOB_AUTH: len_reg <= 5'd25;
                caps_pkg::JOB_POLL: len_reg <= 5'd26;
                default:            len_reg <= 5'd10;
            endcase
            for (int i = 0; i < 8; i++)
            begin
                k_reg[i]   <= q_mem[rp_reg].key_high[8*(7-i) +: 8];
                k_reg[8+i] <= q_mem[rp_reg].key_low[8*(7-i) +: 8];
            end
            for (int i = 0; i < 16; i++)
            begin
                logic [7:0] pb;
                pb = (i < 4) ? q_mem[rp_reg].chal[8*(3-i) +: 8] : 8'h00;
                s_reg[i] <= pb ^ ((i < 8) ? q_mem[rp_reg].key_high[8*(7-i) +: 8]
                                          : q_mem[rp_reg].key_low[8*(15-i) +: 8]);
            end
        end
        else if (st_reg == caps_pkg::BK_AES)
        begin
            for (int i = 0; i < 16; i++)
            begin
                s_reg[i] <= ((rnd_reg == 4'd10) ? sr[i] : mc[i]) ^ kn[i];
                k_reg[i] <= kn[i];
            end
            rc_reg  <= caps_pkg::xt(rc_reg);
            rnd_reg <= rnd_reg + 4'd1;
            // header checksum part: 10 11 10 20 00
            sum_reg <= 16'h0051;
        end
        else if (send_fire)
        begin
            idx_reg <= idx_reg + 5'd1;
            if (idx_reg >= 5'd7 && idx_reg < 5'd23)
                sum_reg <= sum_reg + 16'(byte_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (send_fire)
            ov_reg <= 1'b1;
        else if (out_ch.ready)
            ov_reg <= 1'b0;
    end

    // each event queues at most one job, so a job's last byte ends the run
    always_ff @(posedge clk)
    begin
        if (send_fire)
        begin
            ob_reg  <= byte_c;
            ofe_reg <= (idx_reg == len_reg - 5'd1) || (cur_reg.job == caps_pkg::JOB_POLL
                                                      && idx_reg == 5'd12);
            ore_reg <= (idx_reg == len_reg - 5'd1);
            oph_reg <= cur_reg.phase;
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.tx_byte   = ob_reg;
    assign out_ch.frame_end = ofe_reg;
    assign out_ch.run_end   = ore_reg;
    assign out_ch.phase     = oph_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(QD))
        else $error("queue overflow");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> ov_reg && $stable(ob_reg))
        else $error("output changed while stalled");
    a_aes_length: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == caps_pkg::BK_AES) |-> rnd_reg <= 4'd10)
        else $error("aes round overrun");
`endif
endmodule
`default_nettype wire
